FILE: src/trrs_pkg.sv
// Shared constants and types of the tick round-robin scheduler.
package trrs_pkg;
   localparam int MAX_JOBS = 64;
   localparam int SLOT_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [0:0] REG_POLICY = 1'b0;
   localparam logic [0:0] REG_SLICE = 1'b1;

   typedef struct packed {
      logic [15:0] ident;
      logic [15:0] arrival;
   } job_rec_type;

   typedef struct packed {
      logic [31:0] tick_time;
      logic        cpu_busy;
      logic [15:0] running_id;
      logic        first_dispatch;
      logic [31:0] response_time;
      logic        job_finished;
      logic [31:0] turnaround_time;
      logic [15:0] switch_count;
      logic        all_finished;
   } rsp_type;
endpackage

FILE: src/tick_round_robin_scheduler.sv
// Top level of the tick round-robin scheduler with its sequencer.
//
// Channel  Dir  Handshake            Contents
// req      in   req_tvalid/tready    tuser opcode, tdata id/arrival/burst
// rsp      out  rsp_tvalid/tready    tdata tick result
// csr      in   csr_wr_en            policy_mode, time_slice
//
// A load is written to the job memory if the table has room. A tick checks each pending
// arrival in turn, queues those that are due, dispatches from the queue when no job runs,
// charges the running job and then offers its result. The job memory and the queue each
// have one read port.
// Reset is synchronous; the started marks live in memory, so a clearing pass
// over all MAX_JOBS slots follows reset before the first item is taken.
// A stalled rsp holds the result; the next item is taken once it is gone.
module tick_round_robin_scheduler
   import trrs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [0:0]   req_tuser,  // opcode
   input  logic [47:0]  req_tdata,  // job_id, arrival_time, burst_length
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tick_time, cpu_busy, running_id, first_dispatch, response_time,
   // job_finished, turnaround_time, switch_count, all_finished
   output logic [135:0] rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [0:0]   csr_index,
   input  logic [7:0]   csr_wdata
);
   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_ARD = 4'd2, S_ACHK = 4'd3,
      S_DRD = 4'd4, S_DJOB = 4'd5, S_RUN = 4'd6, S_RUN2 = 4'd7, S_OUT = 4'd8;

   logic [3:0] state_ff, state_in;
   logic policy_ff;
   logic [7:0] slice_cfg_ff;
   logic [SLOT_W-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [CNT_W-1:0] fill_ff, fill_in, loaded_ff, loaded_in, next_ff, next_in;
   logic [CNT_W-1:0] done_ff, done_in, clr_ff, clr_in;
   logic cur_valid_ff, cur_valid_in, last_valid_ff, last_valid_in;
   logic [7:0] used_ff, used_in;
   logic [31:0] tick_ff, tick_in;
   logic [15:0] sw_ff, sw_in, last_id_ff, last_id_in;
   logic out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic jw_en, jw_st, jr_st, qw_en;
   logic [SLOT_W-1:0] jw_addr, jr_addr, qw_addr, qw_data, qr_addr, qr_data;
   job_rec_type jw_rec, jr_rec;
   logic [15:0] jw_rem, jr_rem, burst;
   logic [32:0] tat_full;

   trrs_job_mem u_job (.clock, .wr_en(jw_en), .wr_addr(jw_addr), .wr_rec(jw_rec),
      .wr_rem(jw_rem), .wr_started(jw_st), .rd_addr(jr_addr), .rd_rec(jr_rec),
      .rd_rem(jr_rem), .rd_started(jr_st));
   trrs_fifo_mem u_fifo (.clock, .wr_en(qw_en), .wr_addr(qw_addr), .wr_data(qw_data),
      .rd_addr(qr_addr), .rd_data(qr_data));

   assign req_tready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {4'd0, out_ff.all_finished, out_ff.switch_count,
      out_ff.turnaround_time, out_ff.job_finished, out_ff.response_time,
      out_ff.first_dispatch, out_ff.running_id, out_ff.cpu_busy, out_ff.tick_time};
   assign burst = (req_tdata[47:32] == 16'd0) ? 16'd1 : req_tdata[47:32];
   assign tat_full = {1'b0, tick_ff} + 33'd1 - {17'd0, jr_rec.arrival};

   always_comb begin
      state_in = state_ff; head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff;
      fill_in = fill_ff; loaded_in = loaded_ff; next_in = next_ff; done_in = done_ff;
      clr_in = clr_ff; cur_valid_in = cur_valid_ff; last_valid_in = last_valid_ff;
      used_in = used_ff; tick_in = tick_ff; sw_in = sw_ff; last_id_in = last_id_ff;
      out_valid_in = out_valid_ff && !rsp_tready; out_in = out_ff;
      jw_en = 1'b0; jw_addr = cur_ff; jw_rec = jr_rec; jw_rem = jr_rem; jw_st = jr_st;
      jr_addr = cur_ff; qw_en = 1'b0; qw_addr = tail_ff; qw_data = cur_ff; qr_addr = head_ff;
      unique case (state_ff)
         S_CLR: begin
            jw_en = 1'b1; jw_addr = clr_ff[SLOT_W-1:0]; jw_st = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CNT_W'(MAX_JOBS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (req_tuser[0] == OP_LOAD) begin
                  if (loaded_ff < CNT_W'(MAX_JOBS)) begin
                     jw_en = 1'b1; jw_addr = loaded_ff[SLOT_W-1:0];
                     jw_rec.ident = req_tdata[15:0]; jw_rec.arrival = req_tdata[31:16];
                     jw_rem = burst; jw_st = 1'b0;
                     loaded_in = loaded_ff + 1'b1;
                  end
               end else begin
                  out_in = '0; out_in.tick_time = tick_ff;
                  state_in = S_ARD;
               end
            end
         end
         S_ARD: begin
            jr_addr = next_ff[SLOT_W-1:0];
            state_in = (next_ff < loaded_ff) ? S_ACHK : S_DRD;
         end
         S_ACHK: begin
            if ({16'd0, jr_rec.arrival} <= tick_ff) begin
               if (fill_ff < CNT_W'(MAX_JOBS)) begin
                  qw_en = 1'b1; qw_data = next_ff[SLOT_W-1:0];
                  tail_in = (tail_ff == SLOT_W'(MAX_JOBS - 1)) ? '0 : tail_ff + 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
               next_in = next_ff + 1'b1;
               state_in = S_ARD;
            end else state_in = S_DRD;
         end
         S_DRD: begin
            if (!cur_valid_ff && fill_ff != '0) begin
               head_in = (head_ff == SLOT_W'(MAX_JOBS - 1)) ? '0 : head_ff + 1'b1;
               fill_in = fill_ff - 1'b1;
               state_in = S_DJOB;
            end else state_in = S_RUN;
         end
         S_DJOB: begin
            cur_in = qr_data; cur_valid_in = 1'b1; used_in = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            state_in = cur_valid_ff ? S_RUN2 : S_OUT;
         end
         S_RUN2: begin
            if (!jr_st) begin
               out_in.first_dispatch = 1'b1;
               out_in.response_time = tick_ff - {16'd0, jr_rec.arrival};
            end
            out_in.cpu_busy = 1'b1; out_in.running_id = jr_rec.ident;
            if (last_valid_ff && jr_rec.ident != last_id_ff && sw_ff != 16'hFFFF)
               sw_in = sw_ff + 1'b1;
            last_id_in = jr_rec.ident; last_valid_in = 1'b1;
            jw_en = 1'b1; jw_st = 1'b1;
            jw_rem = (jr_rem != 16'd0) ? jr_rem - 1'b1 : 16'd0;
            used_in = (used_ff != 8'hFF) ? used_ff + 1'b1 : used_ff;
            if (jw_rem == 16'd0) begin
               out_in.job_finished = 1'b1;
               out_in.turnaround_time = tat_full[32] ? 32'hFFFFFFFF : tat_full[31:0];
               cur_valid_in = 1'b0; used_in = '0;
               if (done_ff < CNT_W'(MAX_JOBS)) done_in = done_ff + 1'b1;
            end else if (policy_ff && used_in >= slice_cfg_ff) begin
               if (fill_ff < CNT_W'(MAX_JOBS)) begin
                  qw_en = 1'b1;
                  tail_in = (tail_ff == SLOT_W'(MAX_JOBS - 1)) ? '0 : tail_ff + 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
               cur_valid_in = 1'b0; used_in = '0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            out_in.switch_count = sw_ff;
            out_in.all_finished = (loaded_ff != '0) && (done_ff == loaded_ff);
            out_valid_in = 1'b1;
            if (tick_ff != 32'hFFFFFFFF) tick_in = tick_ff + 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; policy_ff <= 1'b0; slice_cfg_ff <= 8'd1;
         head_ff <= '0; tail_ff <= '0; cur_ff <= '0; fill_ff <= '0; loaded_ff <= '0;
         next_ff <= '0; done_ff <= '0; clr_ff <= '0; cur_valid_ff <= 1'b0;
         last_valid_ff <= 1'b0; used_ff <= '0; tick_ff <= '0; sw_ff <= '0;
         last_id_ff <= '0; out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; head_ff <= head_in; tail_ff <= tail_in; cur_ff <= cur_in;
         fill_ff <= fill_in; loaded_ff <= loaded_in; next_ff <= next_in; done_ff <= done_in;
         clr_ff <= clr_in; cur_valid_ff <= cur_valid_in; last_valid_ff <= last_valid_in;
         used_ff <= used_in; tick_ff <= tick_in; sw_ff <= sw_in; last_id_ff <= last_id_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_POLICY: policy_ff <= csr_wdata[0];
               REG_SLICE: slice_cfg_ff <= (csr_wdata == 8'd0) ? 8'd1 : csr_wdata;
               default: ;
            endcase
         end
      end
      out_ff <= out_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_JOBS)) else $error("queue fill overflow");
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff <= loaded_ff) else $error("more jobs done than loaded");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result lost under stall");
endmodule

FILE: src/trrs_job_mem.sv
// Job table memory: identifier, arrival, remaining ticks and started mark per slot.
module trrs_job_mem
   import trrs_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  job_rec_type       wr_rec,
   input  logic [15:0]       wr_rem,
   input  logic              wr_started,
   input  logic [SLOT_W-1:0] rd_addr,
   output job_rec_type       rd_rec,
   output logic [15:0]       rd_rem,
   output logic              rd_started
);
   job_rec_type mem_rec [MAX_JOBS];
   logic [15:0] mem_rem [MAX_JOBS];
   logic        mem_st  [MAX_JOBS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_rec[wr_addr] <= wr_rec;
         mem_rem[wr_addr] <= wr_rem;
         mem_st[wr_addr] <= wr_started;
      end
      rd_rec <= mem_rec[rd_addr];
      rd_rem <= mem_rem[rd_addr];
      rd_started <= mem_st[rd_addr];
   end
endmodule

FILE: src/trrs_fifo_mem.sv
// Ready queue storage holding job slot numbers.
module trrs_fifo_mem
   import trrs_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  logic [SLOT_W-1:0] wr_data,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [SLOT_W-1:0] rd_data
);
   logic [SLOT_W-1:0] mem [MAX_JOBS];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: verif/tb_top.sv
// Self-checking testbench of the tick round-robin scheduler.
`timescale 1ns / 1ps

module tb_top;
   import trrs_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [0:0]   req_tuser = OP_LOAD;
   logic [47:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic [0:0]   csr_index = REG_POLICY;
   logic [7:0]   csr_wdata = '0;

   tick_round_robin_scheduler dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Scheduler state as predicted by the testbench.
   logic             mode_rr;
   logic [7:0]       quantum;
   logic [15:0]      tbl_id [MAX_JOBS];
   logic [15:0]      tbl_arrival [MAX_JOBS];
   logic [15:0]      tbl_left [MAX_JOBS];
   logic [MAX_JOBS-1:0] started;
   logic [SLOT_W-1:0] ready_slot [MAX_JOBS];
   logic [SLOT_W-1:0] rq_head, rq_tail;
   int               rq_fill, n_loaded, n_arrived, n_done, run_slot, slice_cnt;
   logic             run_valid, last_valid;
   logic [31:0]      tick_cnt;
   logic [15:0]      switches, last_id;

   rsp_type          expected_ticks[$];
   int               errors = 0;
   bit               idling = 1'b1;
   bit               hold_rsp = 1'b0;
   logic [15:0]      last_arrival = 0;

   initial begin
      mode_rr = 1'b0;
      quantum = 8'd1;
      started = '0;
      rq_head = '0;
      rq_tail = '0;
      rq_fill = 0;
      n_loaded = 0;
      n_arrived = 0;
      n_done = 0;
      run_slot = 0;
      slice_cnt = 0;
      run_valid = 1'b0;
      last_valid = 1'b0;
      tick_cnt = '0;
      switches = '0;
      last_id = '0;
   end

   function automatic void push_ready(int slot);
      if (rq_fill < MAX_JOBS) begin
         ready_slot[rq_tail] = slot[SLOT_W-1:0];
         rq_tail = rq_tail + 1'b1;
         rq_fill++;
      end
   endfunction

   function automatic void record_job(logic [15:0] id, logic [15:0] arr, logic [15:0] burst);
      if (n_loaded < MAX_JOBS) begin
         tbl_id[n_loaded] = id;
         tbl_arrival[n_loaded] = arr;
         tbl_left[n_loaded] = (burst == 0) ? 16'd1 : burst;
         started[n_loaded] = 1'b0;
         n_loaded++;
      end
   endfunction

   function automatic rsp_type schedule_tick();
      rsp_type r;
      longint  span;
      r = '0;
      r.tick_time = tick_cnt;
      while (n_arrived < n_loaded && {16'd0, tbl_arrival[n_arrived]} <= tick_cnt) begin
         push_ready(n_arrived);
         n_arrived++;
      end
      if (!run_valid && rq_fill > 0) begin
         run_slot = ready_slot[rq_head];
         rq_head = rq_head + 1'b1;
         rq_fill--;
         run_valid = 1'b1;
         slice_cnt = 0;
         if (!started[run_slot]) begin
            started[run_slot] = 1'b1;
            r.first_dispatch = 1'b1;
            r.response_time = tick_cnt - {16'd0, tbl_arrival[run_slot]};
         end
      end
      if (run_valid) begin
         r.cpu_busy = 1'b1;
         r.running_id = tbl_id[run_slot];
         if (last_valid && r.running_id != last_id && switches != 16'hFFFF)
            switches++;
         last_id = r.running_id;
         last_valid = 1'b1;
         if (tbl_left[run_slot] > 0)
            tbl_left[run_slot]--;
         if (slice_cnt < 255)
            slice_cnt++;
         if (tbl_left[run_slot] == 0) begin
            span = longint'(tick_cnt) + 1 - longint'(tbl_arrival[run_slot]);
            r.turnaround_time = (span > 64'hFFFFFFFF) ? 32'hFFFFFFFF : span[31:0];
            r.job_finished = 1'b1;
            run_valid = 1'b0;
            slice_cnt = 0;
            if (n_done < MAX_JOBS)
               n_done++;
         end else if (mode_rr && slice_cnt >= quantum) begin
            push_ready(run_slot);
            run_valid = 1'b0;
            slice_cnt = 0;
         end
      end
      r.switch_count = switches;
      r.all_finished = (n_loaded != 0 && n_done == n_loaded);
      if (tick_cnt != 32'hFFFFFFFF)
         tick_cnt++;
      return r;
   endfunction

   task automatic send_item(logic op, logic [15:0] id, logic [15:0] arr, logic [15:0] burst);
      int gap;
      gap = idling ? $urandom_range(0, 6) : 0;
      repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {burst, arr, id};
      do @(posedge clock); while (!req_tready);
      if (op == OP_TICK)
         expected_ticks.push_back(schedule_tick());
      else
         record_job(id, arr, burst);
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic wait_idle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [7:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_POLICY)
         mode_rr = value[0];
      else
         quantum = value;
      @(negedge clock) csr_wr_en <= 1'b0;
   endtask

   task automatic load_random_job();
      logic [15:0] arr;
      logic [15:0] id;
      if ($urandom_range(0, 7) == 0)
         arr = tick_cnt[15:0] - 16'($urandom_range(0, 5));
      else
         arr = ((last_arrival > tick_cnt[15:0]) ? last_arrival : tick_cnt[15:0])
               + 16'($urandom_range(0, 8));
      last_arrival = arr;
      id = ($urandom_range(0, 5) == 0) ? tbl_id[n_loaded - 1] : 16'($urandom);
      send_item(OP_LOAD, id, arr, ($urandom_range(0, 9) == 0) ? 16'd0 :
                16'($urandom_range(1, 12)));
   endtask

   task automatic test_fcfs_basic();
      send_tick();
      send_tick();
      send_item(OP_LOAD, 16'h0000, 16'd0, 16'd3);
      send_item(OP_LOAD, 16'hFFFF, 16'd1, 16'd0);
      send_item(OP_LOAD, 16'h0005, 16'd2, 16'd2);
      send_item(OP_LOAD, 16'h0005, 16'd2, 16'd1);
      send_item(OP_LOAD, 16'h0009, 16'd40, 16'd1);
      send_item(OP_LOAD, 16'h000A, 16'd4, 16'd1);
      repeat (10) send_tick();
      last_arrival = 16'd40;
   endtask

   task automatic test_rr_basic();
      wait_idle();
      write_reg(REG_POLICY, 8'd1);
      write_reg(REG_SLICE, 8'd2);
      send_item(OP_LOAD, 16'h1234, 16'd40, 16'd4);
      send_item(OP_LOAD, 16'hABCD, 16'd40, 16'd5);
      while (tick_cnt < 32'd52) send_tick();
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         write_reg(REG_POLICY, phase[0] ? 8'd0 : 8'd1);
         case (phase)
            0: write_reg(REG_SLICE, 8'd1);
            1: write_reg(REG_SLICE, 8'd255);
            2: write_reg(REG_SLICE, 8'd0);
            default: write_reg(REG_SLICE, 8'($urandom_range(1, 6)));
         endcase
         idling = (phase % 3) != 2;
         repeat (76) begin
            if (n_loaded < MAX_JOBS - 3 && $urandom_range(0, 11) == 0)
               load_random_job();
            else
               send_tick();
         end
      end
      idling = 1'b1;
   endtask

   task automatic test_table_limits();
      wait_idle();
      write_reg(REG_POLICY, 8'd1);
      write_reg(REG_SLICE, 8'd3);
      while (n_loaded < MAX_JOBS - 2) load_random_job();
      send_item(OP_LOAD, 16'h7E81, tick_cnt[15:0], 16'hFFFF);
      send_item(OP_LOAD, 16'h8000, 16'hFFFF, 16'h8000);
      send_item(OP_LOAD, 16'h4242, 16'd0, 16'd1);
      send_item(OP_LOAD, 16'h2424, 16'd0, 16'd1);
      repeat (40) send_tick();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         repeat (20) send_tick();
      join
      repeat (20) send_tick();
   endtask

   // Result consumer: random stall per item while idling, long hold when asked.
   int stall_left = 0;
   bit rsp_seen = 1'b0;
   always @(negedge clock) begin
      int wait_n;
      wait_n = rsp_seen ? (idling ? int'($urandom_range(0, 6)) : 0) : stall_left;
      if (hold_rsp || wait_n > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= (wait_n > 0) ? wait_n - 1 : 0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: mismatch in %s: expected %0h, actual %0h", $realtime, name,
                  exp_v, act_v);
         errors++;
      end
   endtask

   int quiet_cycles = 0;
   always @(posedge clock) begin
      rsp_type e;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      rsp_seen <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_ticks.size() == 0) begin
            $display("%0t: unexpected item %0h", $realtime, rsp_tdata);
            errors++;
         end else begin
            e = expected_ticks.pop_front();
            check_field("tick_time", e.tick_time, rsp_tdata[31:0]);
            check_field("cpu_busy", 32'(e.cpu_busy), 32'(rsp_tdata[32]));
            check_field("running_id", 32'(e.running_id), 32'(rsp_tdata[48:33]));
            check_field("first_dispatch", 32'(e.first_dispatch), 32'(rsp_tdata[49]));
            check_field("response_time", e.response_time, rsp_tdata[81:50]);
            check_field("job_finished", 32'(e.job_finished), 32'(rsp_tdata[82]));
            check_field("turnaround_time", e.turnaround_time, rsp_tdata[114:83]);
            check_field("switch_count", 32'(e.switch_count), 32'(rsp_tdata[130:115]));
            check_field("all_finished", 32'(e.all_finished), 32'(rsp_tdata[131]));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_fcfs_basic();
      test_rr_basic();
      test_random();
      test_table_limits();
      test_backpressure();
      @(negedge clock) req_tvalid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_ticks.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
